/* rtl/core/block_coefficient_run_decoder_core_macros.svh */
// assertion macros used by the coefficient run decoder datapath
`ifndef BLOCK_COEFFICIENT_RUN_DECODER_CORE_MACROS_SVH
`define BLOCK_COEFFICIENT_RUN_DECODER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define BCRD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define BCRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/bcrd_pkg.sv */
// types, constants and helper functions of the coefficient run decoder
package bcrd_pkg;

  localparam int unsigned BLOCK_COEFFS_DEF     = 64;
  localparam int unsigned BLOCKS_PER_GROUP_DEF = 6;

  // symbol class boundaries on the first byte
  localparam logic [7:0] MARKER_BYTE   = 8'hAF;
  localparam logic [7:0] SYM_SHORT_LIM = 8'h80;
  localparam logic [7:0] SYM_MID_LIM   = 8'hA0;
  localparam logic [7:0] SYM_RUN_LIM   = 8'hC0;
  localparam logic [7:0] SYM_ESC_LIM   = 8'hE0;
  localparam logic [7:0] ESC_WORD_LIM  = 8'hF0;
  localparam logic [7:0] ESC_RUN1_LIM  = 8'hF4;
  localparam logic [7:0] ESC_LONG_LIM  = 8'hF8;
  localparam logic [7:0] SYM_UNDEF_LIM = 8'hFC;

  localparam logic [2:0] KIND_U = 3'd4;
  localparam logic [2:0] KIND_V = 3'd5;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       row_start;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] coefficient;
    logic        [5:0]  position;
    logic        [2:0]  block_kind;
    logic               block_last;
    logic               decode_error;
  } out_beat_t;

  typedef enum logic [1:0] {
    EMIT_VAL  = 2'd0,
    EMIT_ZERO = 2'd1,
    EMIT_FILL = 2'd2
  } emit_sel_e;

  typedef struct packed {
    logic      accept;
    logic      emit;
    emit_sel_e sel;
  } cmd_t;

  typedef struct packed {
    logic dec_has;
    logic dec_lead;
    logic dec_zero;
    logic dec_tail;
    logic job_tail;
    logic job_fill;
    logic zcnt_one;
    logic emit_last;
    logic out_ready;
  } sts_t;

  // zigzag sign unfold, logical shift
  function automatic logic [31:0] unfold(input logic [31:0] j);
    return (j >> 1) ^ {32{j[0]}};
  endfunction

  // bytes that follow an escape prefix
  function automatic logic [2:0] escape_len(input logic [7:0] b);
    logic [2:0] len;
    if (b < ESC_WORD_LIM) begin
      len = 3'd1;
    end else if (b < ESC_RUN1_LIM) begin
      len = 3'd2;
    end else if (b < ESC_LONG_LIM) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage

/* rtl/core/block_coefficient_run_decoder_core.sv */
// top level of the block coefficient run decoder
// usage:
//   input channel: one stream byte per beat with its row_start flag, taken
//   on in_valid_i high and in_stall_o low
//   output channel: one coefficient per beat with position, block kind,
//   block_last and decode_error, taken on out_valid_o high and out_stall_i low
// timing:
//   a byte that yields no coefficient (escape byte, block marker) is done
//   when it is accepted; a byte that yields n coefficients occupies the
//   accept cycle, then one coefficient per cycle from the emit sequencer
//   while the output is not stalled, paced by the single output register
//   the first coefficient passes the sequencer state register, then the output register
//   a zero fill of a whole block can come from a single byte
// backpressure:
//   while out_stall_i holds a beat the sequencer waits and in_stall_o stays
//   high; the next byte can be taken while the last coefficient still waits
// reset:
//   rst_ni low clears position, block counter, dc predictors and any
//   partly read escape; no clearing pass is needed after reset
module block_coefficient_run_decoder_core import bcrd_pkg::*; #(
  parameter int unsigned BlockCoeffs    = BLOCK_COEFFS_DEF,
  parameter int unsigned BlocksPerGroup = BLOCKS_PER_GROUP_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  // command from sequencer, status back from datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: idle takes a byte, then lead value, zero run, tail value or fill
  bcrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // datapath: symbol decode, escape gather, position, predictors, output beat
  bcrd_datapath #(
    .BlockCoeffs    (BlockCoeffs),
    .BlocksPerGroup (BlocksPerGroup)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_beat_i   (in_beat_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_beat_o  (out_beat_o)
  );

endmodule

/* rtl/core/bcrd_ctrl.sv */
// emit sequencer state machine of the coefficient run decoder
module bcrd_ctrl import bcrd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic in_stall_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LEAD = 5'b00010,
    ST_ZERO = 5'b00100,
    ST_TAIL = 5'b01000,
    ST_FILL = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.sel  = EMIT_VAL;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i && sts_i.dec_has) begin
          priority if (sts_i.dec_lead) begin
            state_d = ST_LEAD;
          end else if (sts_i.dec_zero) begin
            state_d = ST_ZERO;
          end else if (sts_i.dec_tail) begin
            state_d = ST_TAIL;
          end else begin
            state_d = ST_FILL;
          end
        end
      end
      ST_LEAD: begin
        if (sts_i.out_ready) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = EMIT_VAL;
          state_d    = sts_i.job_fill ? ST_FILL : ST_IDLE;
        end
      end
      ST_ZERO: begin
        if (sts_i.out_ready) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = EMIT_ZERO;
          if (sts_i.zcnt_one) begin
            state_d = sts_i.job_tail ? ST_TAIL : ST_IDLE;
          end
        end
      end
      ST_TAIL: begin
        if (sts_i.out_ready) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = EMIT_VAL;
          state_d    = ST_IDLE;
        end
      end
      ST_FILL: begin
        if (sts_i.out_ready) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = EMIT_FILL;
          if (sts_i.emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/bcrd_datapath.sv */
// symbol decode, block position, dc predictors and output register
`include "block_coefficient_run_decoder_core_macros.svh"

module bcrd_datapath import bcrd_pkg::*; #(
  parameter int unsigned BlockCoeffs    = BLOCK_COEFFS_DEF,
  parameter int unsigned BlocksPerGroup = BLOCKS_PER_GROUP_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_beat_t  in_beat_i,
  input  logic      out_stall_i,
  input  cmd_t      cmd_i,
  output sts_t      sts_o,
  output logic      out_valid_o,
  output out_beat_t out_beat_o
);

  localparam int PosW = $clog2(BlockCoeffs);
  localparam int SumW = PosW + 2;
  localparam int CntW = $clog2(BlocksPerGroup);
  localparam logic [SumW-1:0] NCoef    = SumW'(BlockCoeffs);
  localparam logic [CntW:0]   GroupLen = (CntW + 1)'(BlocksPerGroup);

  // decode state
  logic [2:0]      pending_q;
  logic [7:0]      prefix_q;
  logic [31:0]     acc_q;
  logic            marker_q;
  logic [PosW-1:0] pos_q;
  logic [CntW-1:0] blk_q;
  logic [31:0]     pred_luma_q, pred_u_q, pred_v_q;

  // current job
  logic [31:0]     job_val_q;
  logic [5:0]      zcnt_q;
  logic            job_tail_q, job_fill_q, job_err_q;

  logic            out_valid_q;
  out_beat_t       out_q;

  logic [7:0]  b;
  logic [1:0]  esc_k;
  logic [31:0] acc_ins;
  logic        pos_zero;
  logic        sym_done, sym_bad, esc_start, marker_skip, clear_pred;
  logic [5:0]  sym_run;
  logic [31:0] sym_val;
  logic        new_lead, new_tail, new_fill, new_err;
  logic [5:0]  new_zcnt;
  logic [SumW-1:0] pos_ext, run_ext;

  assign b        = in_beat_i.stream_byte;
  assign esc_k    = 2'(escape_len(prefix_q) - pending_q);
  assign acc_ins  = acc_q | (32'(b) << {esc_k, 3'b000});
  assign pos_zero = (pos_q == '0);
  assign pos_ext  = SumW'(pos_q);
  assign run_ext  = SumW'(sym_run);

  // byte classification
  always_comb begin
    sym_done    = 1'b0;
    sym_bad     = 1'b0;
    esc_start   = 1'b0;
    marker_skip = 1'b0;
    clear_pred  = 1'b0;
    sym_run     = '0;
    sym_val     = '0;
    if (pending_q != '0) begin
      if (pending_q == 3'd1) begin
        sym_done = 1'b1;
        sym_val  = unfold(acc_ins);
        priority if (prefix_q < ESC_WORD_LIM) begin
          sym_run = 6'(prefix_q[3:2]);
        end else if (prefix_q >= ESC_RUN1_LIM && prefix_q < ESC_LONG_LIM) begin
          sym_run = 6'd1;
        end else begin
          sym_run = 6'd0;
        end
      end
    end else begin
      clear_pred = pos_zero && in_beat_i.row_start;
      priority if (pos_zero && !marker_q && b == MARKER_BYTE) begin
        marker_skip = 1'b1;
      end else if (b >= SYM_ESC_LIM && b < SYM_UNDEF_LIM) begin
        esc_start = 1'b1;
      end else if (b >= SYM_UNDEF_LIM) begin
        sym_done = 1'b1;
        sym_bad  = 1'b1;
      end else if (b < SYM_SHORT_LIM) begin
        sym_done = 1'b1;
        sym_run  = 6'(b[7:4]);
        sym_val  = unfold(32'(b[3:0]));
      end else if (b < SYM_MID_LIM) begin
        sym_done = 1'b1;
        sym_run  = 6'(b[4:2]) + 6'd8;
        sym_val  = unfold(32'(b[1:0]) + 32'd1);
      end else if (b < SYM_RUN_LIM) begin
        sym_done = 1'b1;
        sym_run  = 6'(b[4:0]) + 6'd1;
      end else begin
        sym_done = 1'b1;
        sym_val  = unfold(32'(b[4:0]) + 32'd16);
      end
    end
  end

  // symbol to job
  always_comb begin
    new_lead = 1'b0;
    new_tail = 1'b0;
    new_fill = 1'b0;
    new_err  = 1'b0;
    new_zcnt = '0;
    priority if (sym_bad) begin
      new_fill = 1'b1;
      new_err  = 1'b1;
    end else if (pos_zero) begin
      priority if (sym_run == 6'd1) begin
        new_lead = 1'b1;
        new_fill = 1'b1;
      end else if (sym_run != '0) begin
        new_fill = 1'b1;
        new_err  = 1'b1;
      end else begin
        new_lead = 1'b1;
      end
    end else if (sym_val == '0) begin
      priority if (sym_run == '0) begin
        new_fill = 1'b1;
      end else if (pos_ext + run_ext > NCoef) begin
        new_fill = 1'b1;
        new_err  = 1'b1;
      end else begin
        new_zcnt = sym_run;
      end
    end else begin
      if (pos_ext + run_ext + SumW'(1) > NCoef) begin
        new_fill = 1'b1;
        new_err  = 1'b1;
      end else begin
        new_zcnt = sym_run;
        new_tail = 1'b1;
      end
    end
  end

  // coefficient formation
  logic [CntW:0] blk_ahead;
  logic [2:0]    kind;
  logic [31:0]   coef_raw, pred_sel, pred_sum, coef_out;
  logic          emit_last, emit_err, out_ready;

  assign blk_ahead = (CntW + 1)'(blk_q) + (CntW + 1)'(2);

  always_comb begin
    priority if (blk_ahead < GroupLen) begin
      kind = 3'(blk_q);
    end else if (blk_ahead == GroupLen) begin
      kind = KIND_U;
    end else begin
      kind = KIND_V;
    end
  end

  always_comb begin
    priority if (kind == KIND_U) begin
      pred_sel = pred_u_q;
    end else if (kind == KIND_V) begin
      pred_sel = pred_v_q;
    end else begin
      pred_sel = pred_luma_q;
    end
  end

  assign coef_raw  = (cmd_i.sel == EMIT_VAL) ? job_val_q : '0;
  assign pred_sum  = pred_sel + coef_raw;
  assign coef_out  = pos_zero ? pred_sum : coef_raw;
  assign emit_last = (pos_ext + SumW'(1)) >= NCoef;
  assign emit_err  = (cmd_i.sel == EMIT_FILL) && job_err_q;
  assign out_ready = !out_valid_q || !out_stall_i;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      marker_q    <= 1'b0;
      pos_q       <= '0;
      blk_q       <= '0;
      pred_luma_q <= '0;
      pred_u_q    <= '0;
      pred_v_q    <= '0;
      zcnt_q      <= '0;
      job_tail_q  <= 1'b0;
      job_fill_q  <= 1'b0;
      job_err_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        if (pending_q != '0) begin
          pending_q <= pending_q - 3'd1;
        end else if (esc_start) begin
          pending_q <= escape_len(b);
        end
        if (marker_skip) begin
          marker_q <= 1'b1;
        end
        if (clear_pred) begin
          pred_luma_q <= '0;
          pred_u_q    <= '0;
          pred_v_q    <= '0;
        end
        if (sym_done) begin
          zcnt_q     <= new_zcnt;
          job_tail_q <= new_tail;
          job_fill_q <= new_fill;
          job_err_q  <= new_err;
        end
      end
      if (cmd_i.emit) begin
        if (cmd_i.sel == EMIT_ZERO) begin
          zcnt_q <= zcnt_q - 6'd1;
        end
        if (pos_zero) begin
          priority if (kind == KIND_U) begin
            pred_u_q <= pred_sum;
          end else if (kind == KIND_V) begin
            pred_v_q <= pred_sum;
          end else begin
            pred_luma_q <= pred_sum;
          end
        end
        if (emit_last) begin
          pos_q    <= '0;
          marker_q <= 1'b0;
          if ((CntW + 1)'(blk_q) + (CntW + 1)'(1) >= GroupLen) begin
            blk_q <= '0;
          end else begin
            blk_q <= blk_q + CntW'(1);
          end
        end else begin
          pos_q <= pos_q + PosW'(1);
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      if (pending_q != '0) begin
        acc_q <= acc_ins;
      end else if (esc_start) begin
        prefix_q <= b;
        acc_q    <= (b < ESC_WORD_LIM) ? {22'd0, b[1:0], 8'd0} : 32'd0;
      end
      if (sym_done) begin
        job_val_q <= sym_val;
      end
    end
    if (cmd_i.emit) begin
      out_q.coefficient  <= $signed(coef_out);
      out_q.position     <= 6'(pos_q);
      out_q.block_kind   <= kind;
      out_q.block_last   <= emit_last;
      out_q.decode_error <= emit_err;
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.dec_has   = sym_done;
    sts_o.dec_lead  = new_lead;
    sts_o.dec_zero  = (new_zcnt != '0);
    sts_o.dec_tail  = new_tail;
    sts_o.job_tail  = job_tail_q;
    sts_o.job_fill  = job_fill_q;
    sts_o.zcnt_one  = (zcnt_q == 6'd1);
    sts_o.emit_last = emit_last;
    sts_o.out_ready = out_ready;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  `BCRD_ASSERT_IMP(a_accept_no_emit, cmd_i.accept, !cmd_i.emit, "byte taken while emitting")
  `BCRD_ASSERT_NEXT(a_last_wraps, cmd_i.emit && emit_last, pos_q == '0, "block end did not wrap")
  `BCRD_ASSERT_IMP(a_zero_count, cmd_i.emit && cmd_i.sel == EMIT_ZERO, zcnt_q != '0, "run count empty")

endmodule

/* test/coeff_stream_monitor.sv */
// monitor that decodes the accepted byte stream and checks every coefficient beat
`timescale 1ns / 1ps
module coeff_stream_monitor import bcrd_pkg::*; #(
  parameter int unsigned BlockCoeffs    = BLOCK_COEFFS_DEF,
  parameter int unsigned BlocksPerGroup = BLOCKS_PER_GROUP_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_beat_t  in_beat_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_beat_t out_beat_i,
  output int        fail_count_o,
  output int        pending_o
);

  out_beat_t   expected_coeffs [$];
  int          failures;
  int          coeffs_due;

  // decoder state
  int unsigned esc_left;
  logic [7:0]  esc_prefix;
  logic [31:0] esc_value;
  int unsigned coeff_pos;
  int unsigned group_slot;
  logic [31:0] luma_pred;
  logic [31:0] u_pred;
  logic [31:0] v_pred;
  logic        marker_seen;

  assign fail_count_o = failures;
  assign pending_o    = coeffs_due;

  function automatic logic [31:0] unzigzag(input logic [31:0] j);
    return j[0] ? ~(j >> 1) : (j >> 1);
  endfunction

  // payload bytes after an escape prefix
  function automatic int unsigned tail_len(input logic [7:0] p);
    if (p < ESC_WORD_LIM) begin
      return 1;
    end
    return 2 + p[3:2];
  endfunction

  function automatic logic [2:0] plane_kind();
    if (group_slot + 2 < BlocksPerGroup) begin
      return 3'(group_slot);
    end else if (group_slot + 2 == BlocksPerGroup) begin
      return KIND_U;
    end
    return KIND_V;
  endfunction

  task automatic put_coeff(input logic [31:0] coef, input logic err);
    out_beat_t   beat;
    logic [2:0]  kind;
    logic [31:0] value;
    kind  = plane_kind();
    value = coef;
    // dc goes through the plane predictor
    if (coeff_pos == 0) begin
      case (kind)
        KIND_U: begin
          u_pred = u_pred + coef;
          value  = u_pred;
        end
        KIND_V: begin
          v_pred = v_pred + coef;
          value  = v_pred;
        end
        default: begin
          luma_pred = luma_pred + coef;
          value     = luma_pred;
        end
      endcase
    end
    beat.coefficient  = value;
    beat.position     = 6'(coeff_pos);
    beat.block_kind   = kind;
    beat.block_last   = (coeff_pos + 1 >= BlockCoeffs);
    beat.decode_error = err;
    expected_coeffs.push_back(beat);
    if (beat.block_last) begin
      coeff_pos   = 0;
      marker_seen = 1'b0;
      group_slot  = (group_slot + 1 >= BlocksPerGroup) ? 0 : group_slot + 1;
    end else begin
      coeff_pos++;
    end
  endtask

  task automatic fill_block(input logic err);
    repeat (BlockCoeffs - coeff_pos) put_coeff('0, err);
  endtask

  task automatic apply_symbol(input int unsigned run, input logic [31:0] val,
                              input logic bad);
    if (bad) begin
      fill_block(1'b1);
    end else if (coeff_pos == 0) begin
      if (run == 1) begin
        put_coeff(val, 1'b0);
        fill_block(1'b0);
      end else if (run != 0) begin
        fill_block(1'b1);
      end else begin
        put_coeff(val, 1'b0);
      end
    end else if (val == 0) begin
      if (run == 0) begin
        fill_block(1'b0);
      end else if (coeff_pos + run > BlockCoeffs) begin
        fill_block(1'b1);
      end else begin
        repeat (run) put_coeff('0, 1'b0);
      end
    end else if (coeff_pos + run + 1 > BlockCoeffs) begin
      fill_block(1'b1);
    end else begin
      repeat (run) put_coeff('0, 1'b0);
      put_coeff(val, 1'b0);
    end
  endtask

  task automatic decode_stream_byte(input in_beat_t beat);
    logic [7:0]  b;
    int unsigned run;
    logic [31:0] val;
    b = beat.stream_byte;
    if (esc_left != 0) begin
      // little-endian escape payload
      esc_value = esc_value | (32'(b) << (8 * ((tail_len(esc_prefix) - esc_left) & 3)));
      esc_left--;
      if (esc_left == 0) begin
        if (esc_prefix < ESC_WORD_LIM) begin
          run = 32'(esc_prefix[3:2]);
        end else if (esc_prefix >= ESC_RUN1_LIM && esc_prefix < ESC_LONG_LIM) begin
          run = 1;
        end else begin
          run = 0;
        end
        apply_symbol(run, unzigzag(esc_value), 1'b0);
      end
      return;
    end
    if (coeff_pos == 0) begin
      if (beat.row_start) begin
        luma_pred = '0;
        u_pred    = '0;
        v_pred    = '0;
      end
      if (!marker_seen && b == MARKER_BYTE) begin
        marker_seen = 1'b1;
        return;
      end
    end
    if (b >= SYM_ESC_LIM && b < SYM_UNDEF_LIM) begin
      esc_prefix = b;
      esc_left   = tail_len(b);
      esc_value  = (b < ESC_WORD_LIM) ? {22'd0, b[1:0], 8'd0} : '0;
    end else if (b >= SYM_UNDEF_LIM) begin
      apply_symbol(0, '0, 1'b1);
    end else begin
      if (b < SYM_SHORT_LIM) begin
        run = 32'(b[6:4]);
        val = unzigzag({28'd0, b[3:0]});
      end else if (b < SYM_MID_LIM) begin
        run = b[4:2] + 8;
        val = unzigzag(32'(b[1:0]) + 1);
      end else if (b < SYM_RUN_LIM) begin
        run = b[4:0] + 1;
        val = '0;
      end else begin
        run = 0;
        val = unzigzag(32'(b[4:0]) + 16);
      end
      apply_symbol(run, val, 1'b0);
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_beat_t want;
    if (!rst_ni) begin
      expected_coeffs.delete();
      failures    = 0;
      coeffs_due  = 0;
      esc_left    = 0;
      esc_prefix  = '0;
      esc_value   = '0;
      coeff_pos   = 0;
      group_slot  = 0;
      luma_pred   = '0;
      u_pred      = '0;
      v_pred      = '0;
      marker_seen = 1'b0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_coeffs.size() == 0) begin
          $error("coefficient beat with nothing expected: coefficient %0d position %0d",
                 out_beat_i.coefficient, out_beat_i.position);
          failures++;
        end else begin
          want = expected_coeffs.pop_front();
          check_field("coefficient", want.coefficient, out_beat_i.coefficient);
          check_field("position", int'(want.position), int'(out_beat_i.position));
          check_field("block_kind", int'(want.block_kind), int'(out_beat_i.block_kind));
          check_field("block_last", int'(want.block_last), int'(out_beat_i.block_last));
          check_field("decode_error", int'(want.decode_error),
                      int'(out_beat_i.decode_error));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        decode_stream_byte(in_beat_i);
      end
      coeffs_due = expected_coeffs.size();
    end
  end

endmodule

/* test/block_coefficient_run_decoder_core_tb.sv */
// testbench top: byte stream stimulus, output backpressure and verdict
`timescale 1ns / 1ps
module block_coefficient_run_decoder_core_tb import bcrd_pkg::*; ();

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_beat;

  int fail_count;
  int pending_coeffs;
  // idling odds in percent, per beat on the input side, per cycle on the output side
  int tx_gap_pct;
  int rx_stall_pct;
  int stall_left;
  int sent_bytes;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  block_coefficient_run_decoder_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat)
  );

  coeff_stream_monitor coeff_mon (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_beat_i    (in_beat),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_beat_i   (out_beat),
    .fail_count_o (fail_count),
    .pending_o    (pending_coeffs)
  );

  // output backpressure: random stall bursts, odds set per phase
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(99) < rx_stall_pct) begin
        stall_left <= $urandom_range(1, 15);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the beat is taken;
  // valid only changes at falling edges, and once per edge
  task automatic send_byte(input logic [7:0] b, input logic rs);
    int gap;
    if ($urandom_range(99) < tx_gap_pct) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= '{stream_byte: b, row_start: rs};
    // payload holds while stalled
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent_bytes++;
  endtask

  // escape prefix from [lo, hi] followed by its random little-endian payload
  task automatic send_escape(input logic [7:0] lo, input logic [7:0] hi,
                             input int tail, input logic rs);
    send_byte(8'($urandom_range(hi, lo)), rs);
    repeat (tail) send_byte(8'($urandom), 1'($urandom));
  endtask

  // one random symbol, weighted so blocks get filled well past the dc
  task automatic send_symbol();
    int   pick;
    logic rs;
    pick = $urandom_range(99);
    rs   = ($urandom_range(7) == 0);
    if (pick < 3) begin
      send_byte(MARKER_BYTE, rs);
    end else if (pick < 8) begin
      // run 0 value 0: end of block, or a zero dc at the block start
      send_byte(8'h00, rs);
    end else if (pick < 43) begin
      send_byte(8'($urandom_range(SYM_SHORT_LIM - 1, 0)), rs);
    end else if (pick < 53) begin
      send_byte(8'($urandom_range(SYM_MID_LIM - 1, SYM_SHORT_LIM)), rs);
    end else if (pick < 60) begin
      send_byte(8'($urandom_range(SYM_RUN_LIM - 1, SYM_MID_LIM)), rs);
    end else if (pick < 70) begin
      send_byte(8'($urandom_range(SYM_ESC_LIM - 1, SYM_RUN_LIM)), rs);
    end else if (pick < 82) begin
      send_escape(SYM_ESC_LIM, ESC_WORD_LIM - 1, 1, rs);
    end else if (pick < 88) begin
      send_escape(ESC_WORD_LIM, ESC_RUN1_LIM - 1, 2, rs);
    end else if (pick < 93) begin
      send_escape(ESC_RUN1_LIM, ESC_LONG_LIM - 1, 3, rs);
    end else if (pick < 98) begin
      send_escape(ESC_LONG_LIM, SYM_UNDEF_LIM - 1, 4, rs);
    end else begin
      // undefined prefix
      send_byte(8'($urandom_range(8'hFF, SYM_UNDEF_LIM)), rs);
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_beat      = '0;
    out_stall    = 1'b0;
    stall_left   = 0;
    sent_bytes   = 0;
    tx_gap_pct   = 20;
    rx_stall_pct = 10;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // block 0 (luma): marker with row start, then a second marker that decodes
    // as a 16-zero run at the dc, which is a bad dc run
    send_byte(MARKER_BYTE, 1'b1);
    send_byte(MARKER_BYTE, 1'b0);
    // block 1: dc-only block with zero dc, the predictor passes through
    send_byte(8'h10, 1'b0);
    // block 2: two short symbols, a mid symbol and a zero run, then a second run that overruns the block
    send_byte(8'h0F, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    // block 3: c0-df values, a one-byte escape with run 3, a two-byte escape,
    // a single zero and the end of block
    send_byte(8'hC0, 1'b0);
    send_byte(8'hDF, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hF3, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h00, 1'b0);
    // block 4 (u): four-byte escape gives the most negative dc, then an
    // undefined prefix ends the block with errors
    send_byte(8'hFB, 1'b0);
    repeat (4) send_byte(8'hFF, 1'b1);
    send_byte(8'hFC, 1'b0);
    // block 5 (v): three-byte escape with run 1 is a dc-only block
    send_byte(8'hF7, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);

    // random symbols; idling odds are redrawn when a symbol starts at a multiple of 25 beats, none at the end
    while (sent_bytes < 250) begin
      if (sent_bytes > 210) begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end else if (sent_bytes % 25 == 0) begin
        case ($urandom_range(2))
          0: begin
            tx_gap_pct   = 0;
            rx_stall_pct = 0;
          end
          1: begin
            tx_gap_pct   = 10;
            rx_stall_pct = 5;
          end
          default: begin
            tx_gap_pct   = 40;
            rx_stall_pct = 25;
          end
        endcase
      end
      send_symbol();
    end
    in_valid <= 1'b0;

    // drain, then keep watching to catch stray beats
    wait (pending_coeffs == 0);
    repeat (16) @(negedge clk);
    if (fail_count == 0) begin
      $display("block_coefficient_run_decoder_core test passed");
    end else begin
      $display("block_coefficient_run_decoder_core test failed");
    end
    $finish;
  end

  // timeout, several times the slowest legal run
  initial begin
    #2500000;
    $display("block_coefficient_run_decoder_core test failed");
    $finish;
  end

endmodule
